@@ rtl/mpjq_pkg.sv @@
// Shared types and constants for the multilevel priority job queue.
// No dependencies; imported by the front, back and top-level modules.
package mpjq_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned JOB_W      = 8;
  localparam int unsigned LEVEL_W    = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLEVEL_W   = 3;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_SERVE   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_LEVEL = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  // Classification of an accepted item, made by the front.
  typedef enum logic [1:0] {
    KIND_ENQUEUE   = 2'd0,
    KIND_BAD_LEVEL = 2'd1,
    KIND_SERVE     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [JOB_W-1:0]   job;
    logic [LEVEL_W-1:0] level;
  } job_cmd_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

endpackage

@@ rtl/multilevel_priority_job_queue_core.sv @@
// Multilevel priority job queue: one FIFO per level, served in passes.
// An input beat is registered in the front queue, then in the result register;
// a serve also passes the registered job store read. Throughput: enqueue one
// item per cycle unless the output stalls; no new item is taken while a serve
// waits for its store read. Reset clears pointers, counts and bitmaps at once;
// the job store is not cleared and the block takes items from the first cycle.
module multilevel_priority_job_queue_core #(
  parameter int unsigned LEVELS      = 8,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] job_id, [12:8] level, [15:13] zero
  input  logic [mpjq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] served_job, [10:8] served_level, [15:11] zero
  output logic [mpjq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [mpjq_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import mpjq_pkg::*;

  job_cmd_t            cmd;
  logic                cmd_valid, cmd_ready;
  logic [JOB_W-1:0]    out_job;
  logic [SLEVEL_W-1:0] out_level;

  mpjq_front #(
    .LEVELS (LEVELS),
    .ID_BITS(ID_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_job_i   (s_axis_tdata[JOB_W-1:0]),
    .in_level_i (s_axis_tdata[JOB_W+LEVEL_W-1:JOB_W]),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  mpjq_back #(
    .LEVELS     (LEVELS),
    .LEVEL_DEPTH(LEVEL_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(m_axis_tuser),
    .out_job_o   (out_job),
    .out_level_o (out_level)
  );

  assign m_axis_tdata = {(OUT_DATA_W - JOB_W - SLEVEL_W)'(0), out_level, out_job};

endmodule

@@ rtl/mpjq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mpjq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mpjq_front.sv @@
// Front end: accepts input beats, classifies them and buffers them in a
// two-entry queue towards the back end. Depends on mpjq_pkg.
module mpjq_front #(
  parameter int unsigned LEVELS  = 8,
  parameter int unsigned ID_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_cmd_i,
  input  logic [mpjq_pkg::JOB_W-1:0]    in_job_i,
  input  logic [mpjq_pkg::LEVEL_W-1:0]  in_level_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output mpjq_pkg::job_cmd_t            cmd_o
);
  import mpjq_pkg::*;

  job_cmd_t   slot_q [2];
  job_cmd_t   cls_cmd;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  // Classify and mask the job id to the stored width.
  always_comb begin
    cls_cmd.level = in_level_i;
    for (int i = 0; i < JOB_W; i++) begin
      cls_cmd.job[i] = in_job_i[i] & (i < ID_BITS);
    end
    if (in_cmd_i == CMD_SERVE) begin
      cls_cmd.kind = KIND_SERVE;
    end else if (32'(in_level_i) >= 32'(LEVELS)) begin
      cls_cmd.kind = KIND_BAD_LEVEL;
    end else begin
      cls_cmd.kind = KIND_ENQUEUE;
    end
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

@@ rtl/mpjq_back.sv @@
// Back end: per-level FIFO bookkeeping, pass/pending bitmaps, job store RAM
// and the result register. Depends on mpjq_pkg and mpjq_ram.
module mpjq_back #(
  parameter int unsigned LEVELS      = 8,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  mpjq_pkg::job_cmd_t            cmd_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mpjq_pkg::STATUS_W-1:0] out_status_o,
  output logic [mpjq_pkg::JOB_W-1:0]    out_job_o,
  output logic [mpjq_pkg::SLEVEL_W-1:0] out_level_o
);
  import mpjq_pkg::*;

  localparam int unsigned LVL_W     = $clog2(LEVELS);
  localparam int unsigned PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned RAM_DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);
  localparam int unsigned ID_W      = (ID_BITS < JOB_W) ? ID_BITS : JOB_W;

  back_state_e state_q, state_d;

  logic [PTR_W-1:0]    head_q  [LEVELS];
  logic [PTR_W-1:0]    head_d  [LEVELS];
  logic [PTR_W-1:0]    tail_q  [LEVELS];
  logic [PTR_W-1:0]    tail_d  [LEVELS];
  logic [CNT_W-1:0]    count_q [LEVELS];
  logic [CNT_W-1:0]    count_d [LEVELS];
  logic [LEVELS-1:0]   pending_q, pending_d;
  logic [LEVELS-1:0]   pass_q, pass_d;
  logic [LVL_W-1:0]    rd_level_q, rd_level_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [JOB_W-1:0]    out_job_q, out_job_d;
  logic [SLEVEL_W-1:0] out_level_q, out_level_d;

  logic [LEVELS-1:0]   nonempty, hit_pass, hit_pend, base, trimmed;
  logic [LVL_W-1:0]    pass_lvl, pend_lvl, serve_lvl, lvl;
  logic                pass_any, pend_any, serve_any;
  logic                out_free, take;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [ID_W-1:0]     ram_rdata;

  assign lvl         = cmd_i.level[LVL_W-1:0];
  assign out_free    = ~out_valid_q | out_ready_i;
  assign cmd_ready_o = (state_q == BK_IDLE) & out_free;
  assign take        = cmd_valid_i & cmd_ready_o;

  // Pick the serve level: first non-empty level of the pass, else of the
  // pending set, which then becomes the new pass.
  always_comb begin
    pass_lvl = '0;
    pend_lvl = '0;
    pass_any = 1'b0;
    pend_any = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      nonempty[i] = (count_q[i] != '0);
    end
    hit_pass = pass_q & nonempty;
    hit_pend = pending_q & nonempty;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (hit_pass[i]) begin
        pass_lvl = LVL_W'(i);
        pass_any = 1'b1;
      end
      if (hit_pend[i]) begin
        pend_lvl = LVL_W'(i);
        pend_any = 1'b1;
      end
    end
    serve_any = pass_any | pend_any;
    serve_lvl = pass_any ? pass_lvl : pend_lvl;
    base      = pass_any ? pass_q : pending_q;
    // Drop the drained levels with a lower index than the served one.
    for (int i = 0; i < LEVELS; i++) begin
      trimmed[i] = base[i] & (LVL_W'(i) >= serve_lvl);
    end
  end

  assign ram_waddr = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(tail_q[lvl]);
  assign ram_raddr = ADDR_W'(ADDR_W'(serve_lvl) * ADDR_W'(LEVEL_DEPTH))
                   + ADDR_W'(head_q[serve_lvl]);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (take && cmd_i.kind == KIND_SERVE && serve_any) begin
          state_d = BK_READ;
        end
      end
      BK_READ: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    pending_d    = pending_q;
    pass_d       = pass_q;
    rd_level_d   = rd_level_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_status_d = out_status_q;
    out_job_d    = out_job_q;
    out_level_d  = out_level_q;
    ram_we       = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (take) begin
          out_job_d   = '0;
          out_level_d = '0;
          case (cmd_i.kind)
            KIND_ENQUEUE: begin
              out_valid_d = 1'b1;
              if (count_q[lvl] == CNT_W'(LEVEL_DEPTH)) begin
                out_status_d = STATUS_FULL;
              end else begin
                out_status_d = STATUS_OK;
                ram_we       = 1'b1;
                tail_d[lvl]  = (tail_q[lvl] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                             : tail_q[lvl] + PTR_W'(1);
                count_d[lvl] = count_q[lvl] + CNT_W'(1);
                pending_d[lvl] = 1'b1;
              end
            end
            KIND_BAD_LEVEL: begin
              out_valid_d  = 1'b1;
              out_status_d = STATUS_BAD_LEVEL;
            end
            KIND_SERVE: begin
              if (serve_any) begin
                head_d[serve_lvl]  = (head_q[serve_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                                   : head_q[serve_lvl] + PTR_W'(1);
                count_d[serve_lvl] = count_q[serve_lvl] - CNT_W'(1);
                pass_d             = trimmed;
                rd_level_d         = serve_lvl;
                if (!pass_any) begin
                  pending_d = '0;
                end
              end else begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_EMPTY;
                pass_d       = '0;
                pending_d    = '0;
              end
            end
            default: begin
              out_valid_d = out_valid_q & ~out_ready_i;
            end
          endcase
        end
      end
      BK_READ: begin
        // Store data arrives in the cycle after the read was issued.
        out_valid_d  = 1'b1;
        out_status_d = STATUS_OK;
        out_job_d    = JOB_W'(ram_rdata);
        out_level_d  = SLEVEL_W'(rd_level_q);
      end
      default: begin
        out_valid_d = out_valid_q & ~out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pending_q   <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_level_q   <= rd_level_d;
    out_status_q <= out_status_d;
    out_job_q    <= out_job_d;
    out_level_q  <= out_level_d;
  end

  mpjq_ram #(
    .WIDTH(ID_W),
    .DEPTH(RAM_DEPTH)
  ) u_job_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(cmd_i.job[ID_W-1:0]),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_job_o    = out_job_q;
  assign out_level_o  = out_level_q;

endmodule
